>>> src/utf8_codepoint_decoder_assert.svh
// Assertion macros for the UTF-8 decoder. They sample on clk and are held off by rst_n.
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

// Checked only while out of reset.
`define U8CD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define U8CD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/u8cd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package u8cd_pkg;

  localparam int QUEUE_DEPTH_DFLT = 4;
  localparam int CP_W = 31;
  localparam logic [CP_W-1:0] REPLACEMENT = 31'h0000FFFD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            out_last;
  } out_t;

  // One accepted byte's results: cp0 alone, or cp0 then cp1.
  typedef struct packed {
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
    logic            two;
    logic            last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] lead_tail(input logic [7:0] b);
    logic [2:0] t;
    unique casez (b)
      8'b110?????: t = 3'd1;
      8'b1110????: t = 3'd2;
      8'b11110???: t = 3'd3;
      8'b111110??: t = 3'd4;
      8'b1111110?: t = 3'd5;
      default:     t = 3'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

>>> src/utf8_codepoint_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming UTF-8 decoder: one string byte per transfer in, code points out. A byte is
// taken every cycle while the result queue has room; its decode completes in that cycle
// and its zero, one or two code points go to a QUEUE_DEPTH-entry queue. The output stage
// sends one code point per cycle while out_ready allows, so a byte that yields two results
// takes two output transfers, absorbed by the queue. With the queue empty and the output
// free, the first code point passes through a queue entry and then the output register.
// The last result of a string carries out_last. Cut-off sequences give U+FFFD.
module utf8_codepoint_decoder import u8cd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic    push, pop;
  job_t    push_job, head_job;
  q_stat_t q_stat;

  u8cd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  u8cd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  u8cd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> src/u8cd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module u8cd_front import u8cd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_t     in_data,
  input  wire q_stat_t q_stat,
  output logic         push,
  output job_t         push_job
);

  logic [CP_W-1:0] part_r, part_nxt;
  logic [2:0]      due_r, due_nxt, due_mid, due_dec, tail;
  logic [7:0]      b;
  logic            accept, lead_emit, e1, e2, e3;
  logic [CP_W-1:0] lead_val, lead_part, v2, shifted;

  assign b        = in_data.in_byte;
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tail      = lead_tail(b);
    lead_emit = !b[7] || (tail == 3'd0);
    lead_val  = !b[7] ? {23'd0, b} : {25'd0, b[5:0]};
    lead_part = {23'd0, b & (8'h3F >> tail)};
    shifted   = {part_r[CP_W-7:0], b[5:0]};
    due_dec   = due_r - 3'd1;
    e1        = 1'b0;
    e2        = 1'b0;
    v2        = lead_val;
    part_nxt  = part_r;
    due_mid   = due_r;
    if (due_r == 3'd0) begin
      e2 = lead_emit;
      if (!lead_emit) begin
        part_nxt = lead_part;
        due_mid  = tail;
      end
    end else if (b[7:6] == 2'b10) begin
      part_nxt = shifted;
      due_mid  = due_dec;
      e2       = (due_dec == 3'd0);
      v2       = shifted;
    end else begin
      e1      = 1'b1;
      e2      = lead_emit;
      due_mid = 3'd0;
      if (!lead_emit) begin
        part_nxt = lead_part;
        due_mid  = tail;
      end
    end
    e3      = in_data.in_end && (due_mid != 3'd0);
    due_nxt = e3 ? 3'd0 : due_mid;

    push_job.last = in_data.in_end;
    push_job.cp1  = REPLACEMENT;
    if (e1) begin
      push_job.cp0 = REPLACEMENT;
      push_job.cp1 = e2 ? v2 : REPLACEMENT;
      push_job.two = e2 || e3;
    end else if (e2) begin
      push_job.cp0 = v2;
      push_job.two = 1'b0;
    end else begin
      push_job.cp0 = REPLACEMENT;
      push_job.two = 1'b0;
    end
  end

  assign push = accept && (e1 || e2 || e3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r  <= 3'd0;
      part_r <= '0;
    end else if (accept) begin
      due_r  <= due_nxt;
      part_r <= part_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/u8cd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module u8cd_queue import u8cd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output q_stat_t   q_stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_job     = mem[rd_r];
  assign cnt_nxt      = cnt_r + CW'(push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      if (pop)  rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

`include "utf8_codepoint_decoder_assert.svh"

  `U8CD_ASSERT(a_no_overflow, !(push && q_stat.full && !pop), "push into full queue")
  `U8CD_ASSERT(a_no_underflow, !(pop && q_stat.empty), "pop from empty queue")
  `U8CD_ASSERT(a_cnt_step, $past(rst_n) |-> cnt_r == $past(cnt_nxt), "count out of step")

endmodule
`default_nettype wire

>>> src/u8cd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module u8cd_back import u8cd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire job_t    head_job,
  input  wire q_stat_t q_stat,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_t         out_data
);

  logic out_valid_r, phase_r, load;
  out_t out_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop       = load && (phase_r || !head_job.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= !phase_r && head_job.two;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.code_point <= phase_r ? head_job.cp1 : head_job.cp0;
      out_data_r.out_last   <= head_job.last && (phase_r || !head_job.two);
    end
  end

endmodule
`default_nettype wire
